// ===== sv/tbdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbdlp_pkg
// Shared types, constants and helpers of the three-button debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbdlp_pkg;

    // button lanes and counter width
    localparam int NUM_BUTTONS = 3;
    localparam int COUNT_BITS  = 17;

    // lane positions
    localparam int BTN_PREV    = 0;
    localparam int BTN_NEXT    = 1;
    localparam int BTN_CONFIRM = 2;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_DATA_BITS-1:0]  DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0]  LONG_PRESS_RESET = 16'd1000;

    // progress fraction and serial divider sizing
    localparam int PROG_FRAC_BITS = 8;
    localparam int PROG_BITS      = PROG_FRAC_BITS + 1;
    localparam logic [PROG_BITS-1:0] PROG_FULL = PROG_BITS'(1 << PROG_FRAC_BITS);
    localparam int DIV_BITS     = COUNT_BITS + PROG_FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic update;
        logic div_init;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_status_t;

    // saturating counter increment
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/three_button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// three_button_debounce_long_press
// Debounces previous, next and confirm buttons and reports short and long
// presses plus the confirm hold progress, one result per millisecond tick.
//
// Input channel s_*: one beat per tick, three raw active-low levels.
// Result channel m_*: one beat per tick, short/long flags per button and
// confirm_progress, a Q1.8 fraction of the long-press time (256 = full).
// Config channel cfg_*: always ready; index 0 is the debounce time, index 1
// the long-press time, other indexes are ignored. Write only while idle.
//
// Sequence: the input beat is taken in the idle state, then the divider is
// loaded, 25 serial divider steps run (one quotient bit a cycle of
// held*256 / long-press time) and the result register is loaded.
// A new tick is taken only in the idle state, once the previous result has
// been loaded into the output register.
// When the receiver stalls, one more tick is taken and computed, then waits
// until the output register frees; further ticks are held off meanwhile.
// Reset restores the default times (50 and 1000), idle levels on all
// buttons and cleared counters; no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module three_button_debounce_long_press (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tbdlp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [tbdlp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // input ticks
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_prev_level,
    input  wire logic                                   s_next_level,
    input  wire logic                                   s_confirm_level,
    // results
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_prev_short,
    output logic                                        m_prev_long,
    output logic                                        m_next_short,
    output logic                                        m_next_long,
    output logic                                        m_confirm_short,
    output logic                                        m_confirm_long,
    output logic [tbdlp_pkg::PROG_BITS-1:0]             m_confirm_progress
);
    import tbdlp_pkg::*;

    ctrl_cmd_t              cmd;
    dp_status_t             status;
    logic [NUM_BUTTONS-1:0] levels;
    logic [NUM_BUTTONS-1:0] ev_short;
    logic [NUM_BUTTONS-1:0] ev_long;

    // gather lane levels
    always_comb begin
        levels              = '1;
        levels[BTN_PREV]    = s_prev_level;
        levels[BTN_NEXT]    = s_next_level;
        levels[BTN_CONFIRM] = s_confirm_level;
    end

    tbdlp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tbdlp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (levels),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .ev_short  (ev_short),
        .ev_long   (ev_long),
        .progress  (m_confirm_progress)
    );

    // spread lane flags onto named ports
    assign m_prev_short    = ev_short[BTN_PREV];
    assign m_prev_long     = ev_long[BTN_PREV];
    assign m_next_short    = ev_short[BTN_NEXT];
    assign m_next_long     = ev_long[BTN_NEXT];
    assign m_confirm_short = ev_short[BTN_CONFIRM];
    assign m_confirm_long  = ev_long[BTN_CONFIRM];

endmodule

`default_nettype wire

// ===== sv/tbdlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbdlp_ctrl
// Sequencer: takes a tick, runs the progress divider, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbdlp_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  tbdlp_pkg::dp_status_t       status,
    output tbdlp_pkg::ctrl_cmd_t        cmd
);
    import tbdlp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.update = s_valid;
            end
            ST_PREP: begin
                cmd.div_init = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // a taken tick always starts the divider next
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> cmd.div_init)
        else $error("divider not started after tick");

    // no new tick while a division is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_ready)
        else $error("input taken during division");

    // a result is handed off only after the last divider step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && !$past(cmd.out_load)) |-> $past(status.div_last) || $past(state_reg == ST_DONE))
        else $error("result loaded before division finished");

endmodule

`default_nettype wire

// ===== sv/tbdlp_dp.sv =====
// ----------------------------------------------------------------------------
// tbdlp_dp
// Datapath: per-button debounce lanes, config registers, serial progress
// divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbdlp_dp (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration writes
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tbdlp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [tbdlp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // raw levels of the tick
    input  wire logic [tbdlp_pkg::NUM_BUTTONS-1:0]      levels,
    // controller link
    input  tbdlp_pkg::ctrl_cmd_t                        cmd,
    output tbdlp_pkg::dp_status_t                       status,
    // result
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [tbdlp_pkg::NUM_BUTTONS-1:0]           ev_short,
    output logic [tbdlp_pkg::NUM_BUTTONS-1:0]           ev_long,
    output logic [tbdlp_pkg::PROG_BITS-1:0]             progress
);
    import tbdlp_pkg::*;

    // configuration
    logic [CFG_DATA_BITS-1:0] deb_reg, deb_next;
    logic [CFG_DATA_BITS-1:0] lpt_reg, lpt_next;

    // per-button state
    logic [NUM_BUTTONS-1:0] raw_reg,    raw_next;
    logic [NUM_BUTTONS-1:0] stable_reg, stable_next;
    logic [NUM_BUTTONS-1:0] active_reg, active_next;
    logic [NUM_BUTTONS-1:0] done_reg,   done_next;
    logic [NUM_BUTTONS-1:0] short_reg,  short_next;
    logic [NUM_BUTTONS-1:0] long_reg,   long_next;
    logic [COUNT_BITS-1:0]  tsc_reg  [NUM_BUTTONS];
    logic [COUNT_BITS-1:0]  tsc_next [NUM_BUTTONS];
    logic [COUNT_BITS-1:0]  held_reg [NUM_BUTTONS];
    logic [COUNT_BITS-1:0]  held_next[NUM_BUTTONS];

    // divider
    logic [CFG_DATA_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0]      quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [CFG_DATA_BITS:0]   trial;
    logic                     trial_ge;

    // result register
    logic                   m_valid_reg,  m_valid_next;
    logic [NUM_BUTTONS-1:0] o_short_reg,  o_short_next;
    logic [NUM_BUTTONS-1:0] o_long_reg,   o_long_next;
    logic [PROG_BITS-1:0]   o_prog_reg,   o_prog_next;
    logic                   prog_on;
    logic [PROG_BITS-1:0]   prog_val;

    assign cfg_ready = 1'b1;

    // config register writes, unknown indexes dropped
    always_comb begin
        deb_next = deb_reg;
        lpt_next = lpt_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE:   deb_next = cfg_data;
                REG_LONG_PRESS: lpt_next = cfg_data;
                default: begin
                    deb_next = deb_reg;
                end
            endcase
        end
    end

    // debounce and press tracking, one independent lane per button
    always_comb begin
        logic [COUNT_BITS-1:0] held_inc;
        logic [COUNT_BITS-1:0] tsc_new;
        logic                  raw_new;
        raw_next    = raw_reg;
        stable_next = stable_reg;
        active_next = active_reg;
        done_next   = done_reg;
        short_next  = short_reg;
        long_next   = long_reg;
        tsc_next    = tsc_reg;
        held_next   = held_reg;
        held_inc    = '0;
        tsc_new     = '0;
        raw_new     = 1'b1;
        if (cmd.update) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                short_next[b] = 1'b0;
                long_next[b]  = 1'b0;
                held_inc = active_reg[b] ? sat_inc(held_reg[b]) : held_reg[b];
                if (levels[b] != raw_reg[b]) begin
                    raw_new = levels[b];
                    tsc_new = '0;
                end else begin
                    raw_new = raw_reg[b];
                    tsc_new = sat_inc(tsc_reg[b]);
                end
                raw_next[b]  = raw_new;
                tsc_next[b]  = tsc_new;
                held_next[b] = held_inc;
                if (tsc_new > COUNT_BITS'(deb_reg)) begin
                    if (raw_new != stable_reg[b]) begin
                        // level committed
                        stable_next[b] = raw_new;
                        held_next[b]   = '0;
                        done_next[b]   = 1'b0;
                        active_next[b] = !raw_new;
                        short_next[b]  = raw_new && !done_reg[b];
                    end else if (!stable_reg[b] && active_reg[b] && !done_reg[b]
                                 && held_inc >= COUNT_BITS'(lpt_reg)) begin
                        // long-press threshold reached
                        long_next[b] = 1'b1;
                        done_next[b] = 1'b1;
                    end
                end
            end
        end
    end

    // restoring division of held*256 by the long-press time, one bit a cycle
    assign trial    = {rem_reg, quo_reg[DIV_BITS-1]};
    assign trial_ge = trial >= {1'b0, lpt_reg};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_init) begin
            rem_next = '0;
            quo_next = {held_reg[BTN_CONFIRM], PROG_FRAC_BITS'(0)};
            cnt_next = '0;
        end else if (cmd.div_step) begin
            rem_next = trial_ge ? CFG_DATA_BITS'(trial - {1'b0, lpt_reg})
                                : trial[CFG_DATA_BITS-1:0];
            quo_next = {quo_reg[DIV_BITS-2:0], trial_ge};
            cnt_next = cnt_reg + DIV_CNT_BITS'(1);
        end
    end

    assign status.div_last = (cnt_reg == DIV_CNT_BITS'(DIV_BITS - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    // confirm progress, shown only while held and before the long event
    assign prog_on = !stable_reg[BTN_CONFIRM] && active_reg[BTN_CONFIRM]
                     && !done_reg[BTN_CONFIRM];

    always_comb begin
        if (!prog_on) begin
            prog_val = '0;
        end else if (lpt_reg == '0) begin
            prog_val = PROG_FULL;
        end else if (quo_reg > DIV_BITS'(PROG_FULL)) begin
            prog_val = PROG_FULL;
        end else begin
            prog_val = quo_reg[PROG_BITS-1:0];
        end
    end

    // result register and its beat handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        o_short_next = o_short_reg;
        o_long_next  = o_long_reg;
        o_prog_next  = o_prog_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            o_short_next = short_reg;
            o_long_next  = long_reg;
            o_prog_next  = prog_val;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg     <= DEBOUNCE_RESET;
            lpt_reg     <= LONG_PRESS_RESET;
            raw_reg     <= '1;
            stable_reg  <= '1;
            active_reg  <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                tsc_reg[b]  <= '0;
                held_reg[b] <= '0;
            end
        end else begin
            deb_reg     <= deb_next;
            lpt_reg     <= lpt_next;
            raw_reg     <= raw_next;
            stable_reg  <= stable_next;
            active_reg  <= active_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            tsc_reg     <= tsc_next;
            held_reg    <= held_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        short_reg   <= short_next;
        long_reg    <= long_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        o_short_reg <= o_short_next;
        o_long_reg  <= o_long_next;
        o_prog_reg  <= o_prog_next;
    end

    assign m_valid  = m_valid_reg;
    assign ev_short = o_short_reg;
    assign ev_long  = o_long_reg;
    assign progress = o_prog_reg;

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // progress never exceeds full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (o_prog_reg <= PROG_FULL))
        else $error("progress above full scale");

    // a button never reports short and long in the same beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((o_short_reg & o_long_reg) == '0))
        else $error("short and long event together");

endmodule

`default_nettype wire

// ===== tb/sv/tb_three_button_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// tb_three_button_debounce_long_press
// Self-checking bench for the three-button debouncer. A scoreboard class runs
// its own model of the debounce, short/long press and confirm progress logic
// on every accepted tick and checks each result beat against it in order.
// Directed ticks cover reset timing, ignored register indexes, a zero long
// time and plain short presses. Random phases follow with bouncing press and
// release runs under several debounce and long-press settings, extremes
// included, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_three_button_debounce_long_press;
    timeunit 1ns;
    timeprecision 1ps;

    import tbdlp_pkg::*;

    // register indexes the block must ignore
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    localparam int NUM_PHASES = 10;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic                 prev_short;
        logic                 prev_long;
        logic                 next_short;
        logic                 next_long;
        logic                 confirm_short;
        logic                 confirm_long;
        logic [PROG_BITS-1:0] confirm_progress;
    } press_result_t;

    // model of the debouncer plus the queue of results still to arrive
    class press_scoreboard;
        logic [CFG_DATA_BITS-1:0] debounce_ticks;
        logic [CFG_DATA_BITS-1:0] hold_ticks;
        bit                       raw_level[NUM_BUTTONS];
        bit                       stable_level[NUM_BUTTONS];
        bit                       pressing[NUM_BUTTONS];
        bit                       long_fired[NUM_BUTTONS];
        logic [COUNT_BITS-1:0]    quiet_ticks[NUM_BUTTONS];
        logic [COUNT_BITS-1:0]    held_ticks[NUM_BUTTONS];
        press_result_t            expected_ticks[$];
        int unsigned              error_count;
        int unsigned              ticks_noted;
        int unsigned              results_checked;
        int unsigned              shorts_seen;
        int unsigned              longs_seen;

        function new();
            debounce_ticks = DEBOUNCE_RESET;
            hold_ticks     = LONG_PRESS_RESET;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                raw_level[b]    = 1'b1;
                stable_level[b] = 1'b1;
                pressing[b]     = 1'b0;
                long_fired[b]   = 1'b0;
                quiet_ticks[b]  = '0;
                held_ticks[b]   = '0;
            end
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_DEBOUNCE) begin
                debounce_ticks = data;
            end else if (idx == REG_LONG_PRESS) begin
                hold_ticks = data;
            end
        endfunction

        // one millisecond of one button
        function void step_button(int b, bit level, output bit shrt, output bit lng);
            shrt = 1'b0;
            lng  = 1'b0;
            if (pressing[b] && held_ticks[b] != '1) begin
                held_ticks[b] = held_ticks[b] + 1'b1;
            end
            if (level != raw_level[b]) begin
                raw_level[b]   = level;
                quiet_ticks[b] = '0;
            end else if (quiet_ticks[b] != '1) begin
                quiet_ticks[b] = quiet_ticks[b] + 1'b1;
            end
            // raw level not yet steady long enough
            if (quiet_ticks[b] <= debounce_ticks) return;
            if (raw_level[b] != stable_level[b]) begin
                stable_level[b] = raw_level[b];
                if (!stable_level[b]) begin
                    pressing[b] = 1'b1;
                end else begin
                    shrt        = !long_fired[b];
                    pressing[b] = 1'b0;
                end
                held_ticks[b] = '0;
                long_fired[b] = 1'b0;
            end else if (!stable_level[b] && pressing[b] && !long_fired[b]
                         && held_ticks[b] >= hold_ticks) begin
                lng           = 1'b1;
                long_fired[b] = 1'b1;
            end
        endfunction

        // confirm hold time as a fraction of the long-press time
        function logic [PROG_BITS-1:0] confirm_fill();
            longint unsigned q;
            if (stable_level[BTN_CONFIRM] || !pressing[BTN_CONFIRM] || long_fired[BTN_CONFIRM])
                return '0;
            if (hold_ticks == '0) return PROG_FULL;
            q = held_ticks[BTN_CONFIRM];
            q = (q * 256) / hold_ticks;
            return (q > 256) ? PROG_FULL : q[PROG_BITS-1:0];
        endfunction

        function void predict_tick(bit prev_lv, bit next_lv, bit confirm_lv);
            press_result_t r;
            bit            s;
            bit            l;
            step_button(BTN_PREV, prev_lv, s, l);
            r.prev_short = s;
            r.prev_long  = l;
            step_button(BTN_NEXT, next_lv, s, l);
            r.next_short = s;
            r.next_long  = l;
            step_button(BTN_CONFIRM, confirm_lv, s, l);
            r.confirm_short    = s;
            r.confirm_long     = l;
            r.confirm_progress = confirm_fill();
            shorts_seen += r.prev_short + r.next_short + r.confirm_short;
            longs_seen  += r.prev_long + r.next_long + r.confirm_long;
            ticks_noted++;
            expected_ticks.push_back(r);
        endfunction

        task report(string msg);
            if (error_count < 40) $display("MISMATCH %s", msg);
            error_count++;
        endtask

        task compare_field(string field, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 results_checked, field, got, want));
        endtask

        task check_result(press_result_t got);
            press_result_t want;
            if (expected_ticks.size() == 0) begin
                report($sformatf("result %0d arrived with no tick pending", results_checked));
            end else begin
                want = expected_ticks.pop_front();
                compare_field("prev_short", got.prev_short, want.prev_short);
                compare_field("prev_long", got.prev_long, want.prev_long);
                compare_field("next_short", got.next_short, want.next_short);
                compare_field("next_long", got.next_long, want.next_long);
                compare_field("confirm_short", got.confirm_short, want.confirm_short);
                compare_field("confirm_long", got.confirm_long, want.confirm_long);
                compare_field("confirm_progress", got.confirm_progress,
                              want.confirm_progress);
            end
            results_checked++;
        endtask
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_prev_level = 1'b1;
    logic                      s_next_level = 1'b1;
    logic                      s_confirm_level = 1'b1;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_prev_short;
    logic                      m_prev_long;
    logic                      m_next_short;
    logic                      m_next_long;
    logic                      m_confirm_short;
    logic                      m_confirm_long;
    logic [PROG_BITS-1:0]      m_confirm_progress;

    press_scoreboard events_sb = new();

    // traffic shaping: steady_flow covers both sides, hold_request the result side
    bit steady_flow = 1'b0;
    bit hold_request = 1'b0;

    // timing the random press generator aims at
    int cur_debounce = DEBOUNCE_RESET;
    int cur_hold = LONG_PRESS_RESET;
    int settings_used = 1;
    bit run_level[NUM_BUTTONS];
    int run_left[NUM_BUTTONS];

    int deb_sets[NUM_PHASES]  = '{0, 1, 2, 0, 3, 65535, 1, 0, 2, 4};
    int hold_sets[NUM_PHASES] = '{1, 3, 0, 5, 8, 2, 65535, 12, 6, 16};

    three_button_debounce_long_press DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_prev_level       (s_prev_level),
        .s_next_level       (s_next_level),
        .s_confirm_level    (s_confirm_level),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_prev_short       (m_prev_short),
        .m_prev_long        (m_prev_long),
        .m_next_short       (m_next_short),
        .m_next_long        (m_next_long),
        .m_confirm_short    (m_confirm_short),
        .m_confirm_long     (m_confirm_long),
        .m_confirm_progress (m_confirm_progress)
    );

    // clock
    always #5 aclk = ~aclk;

    // drive one tick beat and note it once accepted
    task automatic send_tick(input bit prev_lv, input bit next_lv, input bit confirm_lv);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_prev_level    <= prev_lv;
        s_next_level    <= next_lv;
        s_confirm_level <= confirm_lv;
        do @(posedge aclk); while (!s_ready);
        events_sb.predict_tick(prev_lv, next_lv, confirm_lv);
    endtask

    // stop sending and wait for every pending result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (events_sb.expected_ticks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write beat; valid stays up for back-to-back writes
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        events_sb.set_register(idx, data);
    endtask

    task automatic configure(input int deb, input int hold);
        write_register(REG_DEBOUNCE, CFG_DATA_BITS'(deb));
        write_register(REG_LONG_PRESS, CFG_DATA_BITS'(hold));
        cfg_valid    <= 1'b0;
        cur_debounce = deb;
        cur_hold     = hold;
        settings_used++;
    endtask

    // length of the next steady run: mostly long enough to commit, some bounces
    function automatic int draw_run(bit level);
        int dd;
        int ll;
        dd = (cur_debounce > 6) ? 6 : cur_debounce;
        ll = (cur_hold > 20) ? 20 : cur_hold;
        if ($urandom_range(0, 5) == 0) return $urandom_range(1, dd + 1);
        if (!level) return $urandom_range(dd + 1, dd + ll + 4);
        return $urandom_range(dd + 1, dd + 5);
    endfunction

    // press/release runs per button with the odd single-tick glitch
    task automatic random_tick();
        bit [NUM_BUTTONS-1:0] lv;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (run_left[b] == 0) begin
                run_level[b] = ~run_level[b];
                run_left[b]  = draw_run(run_level[b]);
            end
            run_left[b]--;
            lv[b] = run_level[b];
            if ($urandom_range(0, 15) == 0) lv[b] = ~lv[b];
        end
        send_tick(lv[BTN_PREV], lv[BTN_NEXT], lv[BTN_CONFIRM]);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                gap = steady_flow ? 0 : $urandom_range(0, 7);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // result beat check
    always @(posedge aclk) begin
        press_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.prev_short       = m_prev_short;
            got.prev_long        = m_prev_long;
            got.next_short       = m_next_short;
            got.next_long        = m_next_long;
            got.confirm_short    = m_confirm_short;
            got.confirm_long     = m_confirm_long;
            got.confirm_progress = m_confirm_progress;
            events_sb.check_result(got);
        end
    end

    // stimulus
    initial begin
        int n_items;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            run_level[b] = 1'b1;
            run_left[b]  = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset timing: nothing can commit in a few ticks
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        drain();

        // writes to unused indexes must leave the timing alone
        write_register(REG_SPARE_2, '0);
        write_register(REG_SPARE_3, '0);
        cfg_valid <= 1'b0;
        repeat (3) send_tick(1'b0, 1'b0, 1'b0);
        drain();

        // zero debounce and zero long time: long fires right after commit
        configure(0, 0);
        repeat (3) send_tick(1'b0, 1'b0, 1'b0);
        repeat (2) send_tick(1'b1, 1'b1, 1'b1);
        drain();

        // plain short presses on prev and confirm
        configure(1, 4);
        repeat (3) send_tick(1'b0, 1'b1, 1'b0);
        repeat (3) send_tick(1'b1, 1'b1, 1'b1);

        // random phases
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            configure(deb_sets[ph], hold_sets[ph]);
            steady_flow = (ph == 2 || ph == 7);
            if (ph == 4) hold_request = 1'b1;
            for (int b = 0; b < NUM_BUTTONS; b++) run_left[b] = 0;
            n_items = (deb_sets[ph] > 1000) ? 30 : 100;
            repeat (n_items) random_tick();
        end
        steady_flow = 1'b0;
        drain();

        $display("covered %0d ticks under %0d timing settings, %0d results checked",
                 events_sb.ticks_noted, settings_used, events_sb.results_checked);
        $display("expected %0d short and %0d long press events",
                 events_sb.shorts_seen, events_sb.longs_seen);
        if (events_sb.error_count == 0) begin
            $display("tb_three_button_debounce_long_press: clean");
        end else begin
            $display("tb_three_button_debounce_long_press: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("watchdog expired with %0d results pending",
                 events_sb.expected_ticks.size());
        $display("tb_three_button_debounce_long_press: errors");
        $finish;
    end

endmodule

`default_nettype wire
